// ===== sv/stream_pattern_match_trigger_assert.svh =====
// Assertion macros for the pattern match trigger.
`ifndef STREAM_PATTERN_MATCH_TRIGGER_ASSERT_SVH
`define STREAM_PATTERN_MATCH_TRIGGER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPMT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spmt assertion failed");

// Next-cycle implication, checked outside reset.
`define SPMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spmt assertion failed");

`endif

// ===== sv/spmt_pkg.sv =====
package spmt_pkg;

  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = 32;
  localparam int PB_IDX_W   = 5;
  localparam int LEN_W      = 6;
  localparam int SKIP_W     = 16;
  localparam int HALT_W     = 31;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [HALT_W-1:0] HALT_LIMIT = 31'd2000000000;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LENGTH = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HALT_AFTER = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST    = 4'd7;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_COUNTED = 2'd1;
  localparam logic [1:0] EV_FINAL   = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] match_event;
    logic       stop_now;
    logic       armed_flag;
  } out_t;

endpackage

// ===== sv/stream_pattern_match_trigger.sv =====
// Stream pattern match trigger.
// Input channel in_valid/in_ready/in_data carries items that are either a
// received byte (kind 0) or one time tick (kind 1). Each item yields exactly
// one result on out_valid/out_ready/out_data: the match event, whether the
// stop fires on this item, and whether the rule is still armed.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per cycle with no wait; write it only while no item is in flight.
// Throughput: one item per cycle while the skid stage is not full. The whole
// window compare, counters and stop countdown are evaluated combinationally
// from the accepted item into the result register, and a skid stage behind
// it keeps in_ready high for one extra item while out_ready is low; in_ready
// drops only when that skid stage is full, and rises again once the receiver
// takes a result.
// Reset (rst, synchronous): pattern words 0, length 1, repeat count 0,
// halt 0, persist 0, rule armed, no stop pending, fresh count 0, both
// output stages empty. The byte window holds no reset value; only bytes
// received since reset take part in a compare.
module stream_pattern_match_trigger #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  spmt_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output spmt_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [spmt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spmt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int FC_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (FC_W > spmt_pkg::LEN_W) ? FC_W : spmt_pkg::LEN_W;

  logic [spmt_pkg::CFG_DATA_W-1:0] pattern_word [spmt_pkg::PAT_WORDS];
  logic [spmt_pkg::LEN_W-1:0]      pattern_length;
  logic [spmt_pkg::HALT_W-1:0]     halt_after;
  logic                            persist;

  logic [7:0]                  window [MAX_PATTERN];
  logic [7:0]                  win_next [MAX_PATTERN];
  logic [FC_W-1:0]             fresh_count;
  logic [spmt_pkg::SKIP_W-1:0] skips_left;
  logic                        rule_armed;
  logic                        stop_pending;
  logic [spmt_pkg::HALT_W-1:0] stop_countdown;

  logic [FC_W-1:0]             fresh_count_next;
  logic [spmt_pkg::SKIP_W-1:0] skips_left_next;
  logic                        rule_armed_next;
  logic                        stop_pending_next;
  logic [spmt_pkg::HALT_W-1:0] stop_countdown_next;
  logic                        shift_en;
  spmt_pkg::out_t              res;

  logic [8*spmt_pkg::PAT_BYTES-1:0] pat_flat;
  logic [spmt_pkg::LEN_W-1:0]       len_used;
  logic [FC_W-1:0]                  fresh_inc;
  logic [MAX_PATTERN-1:0]           eq_vec;
  logic                             window_hit;
  logic [spmt_pkg::HALT_W-1:0]      halt_clamped;

  spmt_pkg::out_t skid_data;
  logic           skid_valid;
  logic           in_fire;
  logic           out_free;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign pat_flat = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};

  always_comb begin
    if (pattern_length == '0) begin
      len_used = spmt_pkg::LEN_W'(1);
    end else if (pattern_length > spmt_pkg::LEN_W'(MAX_PATTERN)) begin
      len_used = spmt_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      len_used = pattern_length;
    end
  end

  assign fresh_inc = (fresh_count == FC_W'(MAX_PATTERN)) ? fresh_count
                                                         : fresh_count + FC_W'(1);

  // window[0] is the newest byte
  assign win_next[0] = in_data.data_byte;
  for (genvar g = 1; g < MAX_PATTERN; g++) begin : g_shift
    assign win_next[g] = window[g-1];
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cmp
    logic [spmt_pkg::LEN_W-1:0] off;
    assign off = len_used - spmt_pkg::LEN_W'(1) - spmt_pkg::LEN_W'(g);
    assign eq_vec[g] = (spmt_pkg::LEN_W'(g) >= len_used) ||
                       (win_next[g] == pat_flat[{off[spmt_pkg::PB_IDX_W-1:0], 3'b000} +: 8]);
  end

  assign window_hit = (CMP_W'(fresh_inc) >= CMP_W'(len_used)) && (&eq_vec);

  always_comb begin
    fresh_count_next    = fresh_count;
    skips_left_next     = skips_left;
    rule_armed_next     = rule_armed;
    stop_pending_next   = stop_pending;
    stop_countdown_next = stop_countdown;
    shift_en            = 1'b0;
    res.match_event     = spmt_pkg::EV_NONE;
    res.stop_now        = 1'b0;
    if (in_data.kind == spmt_pkg::KIND_TICK) begin
      if (stop_pending) begin
        stop_countdown_next = stop_countdown - spmt_pkg::HALT_W'(1);
        if (stop_countdown_next == '0) begin
          stop_pending_next = 1'b0;
          res.stop_now      = 1'b1;
        end
      end
    end else if (rule_armed) begin
      shift_en         = 1'b1;
      fresh_count_next = fresh_inc;
      if (window_hit) begin
        fresh_count_next = '0;
        if (skips_left != '0) begin
          skips_left_next = skips_left - spmt_pkg::SKIP_W'(1);
          res.match_event = spmt_pkg::EV_COUNTED;
        end else begin
          res.match_event = spmt_pkg::EV_FINAL;
          if (!persist) begin
            rule_armed_next = 1'b0;
          end
          if (!stop_pending) begin
            if (halt_after == '0) begin
              res.stop_now = 1'b1;
            end else begin
              stop_pending_next   = 1'b1;
              stop_countdown_next = halt_after;
            end
          end
        end
      end
    end
    res.armed_flag = rule_armed_next;
  end

  assign halt_clamped = (cfg_data[spmt_pkg::HALT_W-1:0] > spmt_pkg::HALT_LIMIT)
                        ? spmt_pkg::HALT_LIMIT : cfg_data[spmt_pkg::HALT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < spmt_pkg::PAT_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      pattern_length <= spmt_pkg::LEN_W'(1);
      halt_after     <= '0;
      persist        <= 1'b0;
      fresh_count    <= '0;
      skips_left     <= '0;
      rule_armed     <= 1'b1;
      stop_pending   <= 1'b0;
      stop_countdown <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spmt_pkg::REG_PAT_WORD_0, spmt_pkg::REG_PAT_WORD_1,
        spmt_pkg::REG_PAT_WORD_2, spmt_pkg::REG_PAT_WORD_3: begin
          pattern_word[cfg_index[1:0]] <= cfg_data;
        end
        spmt_pkg::REG_PAT_LENGTH: begin
          pattern_length <= cfg_data[spmt_pkg::LEN_W-1:0];
        end
        spmt_pkg::REG_REPEAT: begin
          skips_left <= cfg_data[spmt_pkg::SKIP_W-1:0];
          rule_armed <= 1'b1;
        end
        spmt_pkg::REG_HALT_AFTER: begin
          halt_after <= halt_clamped;
        end
        spmt_pkg::REG_PERSIST: begin
          persist <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      fresh_count    <= fresh_count_next;
      skips_left     <= skips_left_next;
      rule_armed     <= rule_armed_next;
      stop_pending   <= stop_pending_next;
      stop_countdown <= stop_countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && shift_en && !cfg_we) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= win_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= res;
      end
    end else if (in_fire) begin
      skid_data <= res;
    end
  end

`include "stream_pattern_match_trigger_assert.svh"

`SPMT_ASSERT_NOW(a_skid_implies_out, clk, rst, skid_valid, out_valid)
`SPMT_ASSERT_NOW(a_pending_nonzero, clk, rst, stop_pending, stop_countdown != '0)
`SPMT_ASSERT_NEXT(a_stall_fills_skid, clk, rst, in_fire && out_valid && !out_ready, skid_valid)
`SPMT_ASSERT_NOW(a_fresh_bounded, clk, rst, 1'b1, fresh_count <= FC_W'(MAX_PATTERN))

endmodule

// ===== bench/stream_pattern_match_trigger_tb.sv =====
module stream_pattern_match_trigger_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam int ITEM_GOAL = 1800;
  localparam logic [spmt_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [spmt_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;
  localparam logic [spmt_pkg::CFG_IDX_W-1:0] WORD_REG [spmt_pkg::PAT_WORDS] =
    '{spmt_pkg::REG_PAT_WORD_0, spmt_pkg::REG_PAT_WORD_1,
      spmt_pkg::REG_PAT_WORD_2, spmt_pkg::REG_PAT_WORD_3};

  class trigger_tracker;
    logic [spmt_pkg::CFG_DATA_W-1:0] pat_word [spmt_pkg::PAT_WORDS];
    logic [spmt_pkg::LEN_W-1:0] pat_len;
    logic [spmt_pkg::SKIP_W-1:0] repeat_val;
    logic [spmt_pkg::SKIP_W-1:0] skips;
    logic [spmt_pkg::HALT_W-1:0] halt_val;
    logic [spmt_pkg::HALT_W-1:0] countdown;
    logic persist;
    logic armed;
    logic stop_pending;
    logic [7:0] window [spmt_pkg::PAT_BYTES];
    int fresh;
    spmt_pkg::out_t outcome_q [$];
    int mismatches;

    function new();
      foreach (pat_word[i]) pat_word[i] = '0;
      foreach (window[i]) window[i] = '0;
      pat_len = spmt_pkg::LEN_W'(1);
      repeat_val = '0;
      skips = '0;
      halt_val = '0;
      countdown = '0;
      persist = 1'b0;
      armed = 1'b1;
      stop_pending = 1'b0;
      fresh = 0;
      mismatches = 0;
    endfunction

    function logic [7:0] pattern_byte(int i);
      return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function int used_len();
      int n;
      n = pat_len;
      if (n < 1) n = 1;
      if (n > spmt_pkg::PAT_BYTES) n = spmt_pkg::PAT_BYTES;
      return n;
    endfunction

    function void apply(logic [spmt_pkg::CFG_IDX_W-1:0] idx,
                        logic [spmt_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        spmt_pkg::REG_PAT_WORD_0, spmt_pkg::REG_PAT_WORD_1,
        spmt_pkg::REG_PAT_WORD_2, spmt_pkg::REG_PAT_WORD_3: begin
          pat_word[idx[1:0]] = val;
        end
        spmt_pkg::REG_PAT_LENGTH: begin
          pat_len = val[spmt_pkg::LEN_W-1:0];
        end
        spmt_pkg::REG_REPEAT: begin
          repeat_val = val[spmt_pkg::SKIP_W-1:0];
          skips = repeat_val;
          armed = 1'b1;
        end
        spmt_pkg::REG_HALT_AFTER: begin
          halt_val = val[spmt_pkg::HALT_W-1:0];
          if (halt_val > spmt_pkg::HALT_LIMIT) halt_val = spmt_pkg::HALT_LIMIT;
        end
        spmt_pkg::REG_PERSIST: begin
          persist = val[0];
        end
        default: begin
        end
      endcase
    endfunction

    function spmt_pkg::out_t next_outcome(spmt_pkg::in_t it);
      spmt_pkg::out_t r;
      int n;
      bit hit;
      r = '0;
      r.match_event = spmt_pkg::EV_NONE;
      if (it.kind == spmt_pkg::KIND_TICK) begin
        if (stop_pending) begin
          countdown = countdown - spmt_pkg::HALT_W'(1);
          if (countdown == '0) begin
            stop_pending = 1'b0;
            r.stop_now = 1'b1;
          end
        end
      end else if (armed) begin
        for (int i = spmt_pkg::PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = it.data_byte;
        if (fresh < spmt_pkg::PAT_BYTES) fresh++;
        n = used_len();
        hit = (fresh >= n);
        for (int i = 0; i < n; i++)
          if (window[i] != pattern_byte(n - 1 - i)) hit = 1'b0;
        if (hit) begin
          fresh = 0;
          if (skips > 0) begin
            skips--;
            r.match_event = spmt_pkg::EV_COUNTED;
          end else begin
            r.match_event = spmt_pkg::EV_FINAL;
            if (!persist) armed = 1'b0;
            if (!stop_pending) begin
              if (halt_val == '0) begin
                r.stop_now = 1'b1;
              end else begin
                stop_pending = 1'b1;
                countdown = halt_val;
              end
            end
          end
        end
      end
      r.armed_flag = armed;
      return r;
    endfunction

    function void take_item(spmt_pkg::in_t it);
      outcome_q.push_back(next_outcome(it));
    endfunction

    task report(string msg);
      $display("[%0t] %s", $time, msg);
      mismatches++;
    endtask

    task check_outcome(spmt_pkg::out_t got);
      spmt_pkg::out_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("result %p arrived with nothing expected", got));
      end else begin
        want = outcome_q.pop_front();
        if (got.match_event !== want.match_event)
          report($sformatf("match_event: expected %0d, got %0d",
                           want.match_event, got.match_event));
        if (got.stop_now !== want.stop_now)
          report($sformatf("stop_now: expected %0d, got %0d", want.stop_now, got.stop_now));
        if (got.armed_flag !== want.armed_flag)
          report($sformatf("armed_flag: expected %0d, got %0d",
                           want.armed_flag, got.armed_flag));
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  spmt_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  spmt_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [spmt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [spmt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  trigger_tracker tracker = new();
  bit calm = 1'b0;
  bit narrow = 1'b0;
  logic [7:0] alpha [4];
  int counted = 0;
  int cycles = 0;

  stream_pattern_match_trigger dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("stream_pattern_match_trigger regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [spmt_pkg::CFG_IDX_W-1:0] idx,
                           logic [spmt_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    tracker.apply(idx, val);
    @(posedge clk);
  endtask

  task automatic close_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(logic kind, logic [7:0] b);
    spmt_pkg::in_t it;
    int gap;
    it.kind = kind;
    it.data_byte = b;
    gap = calm ? 0 : $urandom_range(0, 9);
    counted++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(it);
  endtask

  // flip < 0 sends the pattern intact; otherwise corrupt that byte
  task automatic send_pattern(int flip);
    logic [7:0] b;
    int n;
    n = tracker.used_len();
    for (int i = 0; i < n; i++) begin
      b = tracker.pattern_byte(i);
      if (i == flip) b = b ^ (8'd1 << $urandom_range(0, 7));
      send(spmt_pkg::KIND_BYTE, b);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_outcome(out_data);
    end
  end

  initial begin
    logic [spmt_pkg::CFG_DATA_W-1:0] word;
    logic [spmt_pkg::CFG_DATA_W-1:0] val;
    int pick;
    int target;
    int start;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: byte 0 matches at once, then the rule is disarmed
    send(spmt_pkg::KIND_BYTE, 8'h00);
    send(spmt_pkg::KIND_BYTE, 8'h00);
    send(spmt_pkg::KIND_TICK, 8'hFF);
    send(spmt_pkg::KIND_BYTE, 8'hFF);
    settle();

    write_reg(REG_UNUSED_LO, {$urandom, $urandom});
    write_reg(REG_UNUSED_HI, {$urandom, $urandom});
    write_reg(spmt_pkg::REG_PAT_WORD_0, {$urandom, $urandom});
    write_reg(spmt_pkg::REG_PAT_LENGTH, 64'd3);
    write_reg(spmt_pkg::REG_REPEAT, 64'd1);
    write_reg(spmt_pkg::REG_HALT_AFTER, 64'd2);
    write_reg(spmt_pkg::REG_PERSIST, 64'd1);
    close_writes();
    send_pattern(-1);
    send_pattern(-1);
    send_pattern(-1);
    send(spmt_pkg::KIND_TICK, 8'h00);
    send(spmt_pkg::KIND_TICK, 8'hFF);
    send(spmt_pkg::KIND_TICK, 8'h5A);
    settle();

    // zero length acts as one byte
    write_reg(spmt_pkg::REG_PAT_LENGTH, 64'd0);
    write_reg(spmt_pkg::REG_REPEAT, 64'd0);
    write_reg(spmt_pkg::REG_HALT_AFTER, 64'd0);
    close_writes();
    send_pattern(-1);
    send(spmt_pkg::KIND_BYTE, ~tracker.pattern_byte(0));
    settle();

    while (counted < ITEM_GOAL) begin
      calm = ($urandom_range(0, 3) == 0);
      narrow = $urandom_range(0, 1);
      foreach (alpha[k]) alpha[k] = 8'($urandom);
      for (int w = 0; w < spmt_pkg::PAT_WORDS; w++) begin
        word = {$urandom, $urandom};
        if (narrow)
          for (int k = 0; k < 8; k++) word[k*8 +: 8] = alpha[$urandom_range(0, 1)];
        write_reg(WORD_REG[w], word);
      end
      val = {$urandom, $urandom};
      pick = $urandom_range(0, 19);
      if (pick == 0)
        val[spmt_pkg::LEN_W-1:0] = '0;
      else if (pick == 1)
        val[spmt_pkg::LEN_W-1:0] = spmt_pkg::LEN_W'($urandom_range(33, 63));
      else if (pick < 4)
        val[spmt_pkg::LEN_W-1:0] = spmt_pkg::LEN_W'(spmt_pkg::PAT_BYTES);
      else
        val[spmt_pkg::LEN_W-1:0] = spmt_pkg::LEN_W'($urandom_range(1, 8));
      write_reg(spmt_pkg::REG_PAT_LENGTH, val);
      val = {$urandom, $urandom};
      val[spmt_pkg::SKIP_W-1:0] = ($urandom_range(0, 14) == 0) ? 16'hFFFF
                                                               : 16'($urandom_range(0, 3));
      write_reg(spmt_pkg::REG_REPEAT, val);
      val = {$urandom, $urandom};
      val[spmt_pkg::HALT_W-1:0] = ($urandom_range(0, 4) == 0)
                                  ? spmt_pkg::HALT_W'($urandom_range(7, 40))
                                  : spmt_pkg::HALT_W'($urandom_range(0, 6));
      write_reg(spmt_pkg::REG_HALT_AFTER, val);
      write_reg(spmt_pkg::REG_PERSIST, {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0)
        write_reg(spmt_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  {$urandom, $urandom});
      close_writes();

      target = $urandom_range(40, 120);
      start = counted;
      while (counted - start < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          send_pattern(($urandom_range(0, 11) == 0) ?
                       int'($urandom_range(0, tracker.used_len() - 1)) : -1);
        end else if (pick < 8) begin
          repeat ($urandom_range(1, 4))
            send(spmt_pkg::KIND_BYTE, narrow ? alpha[$urandom_range(0, 3)] : 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 12)) send(spmt_pkg::KIND_TICK, 8'($urandom));
        end
      end
      settle();
    end

    // run out any pending stop, then load a halt value past the limit
    calm = 1'b0;
    while (tracker.stop_pending) send(spmt_pkg::KIND_TICK, 8'($urandom));
    settle();
    write_reg(spmt_pkg::REG_PAT_WORD_0, {$urandom, $urandom});
    write_reg(spmt_pkg::REG_PAT_LENGTH, 64'd1);
    write_reg(spmt_pkg::REG_REPEAT, 64'd0);
    val = {$urandom, $urandom};
    val[spmt_pkg::HALT_W-1:0] = '1;
    write_reg(spmt_pkg::REG_HALT_AFTER, val);
    write_reg(spmt_pkg::REG_PERSIST, 64'd0);
    close_writes();
    send_pattern(-1);
    repeat (4) send(spmt_pkg::KIND_TICK, 8'($urandom));
    send_pattern(-1);
    send(spmt_pkg::KIND_TICK, 8'($urandom));
    settle();

    if (tracker.mismatches == 0 && tracker.outcome_q.size() == 0) begin
      $display("stream_pattern_match_trigger regression: pass");
    end else begin
      $display("stream_pattern_match_trigger regression: fail");
    end
    $finish;
  end

endmodule
